// File: sv/mfe_pkg.sv
// Shared constants and result type for the marker frame extractor.
package mfe_pkg;

    // Default frame sizes in bytes
    localparam int LONG_FRAME_BYTES_DEF  = 20;
    localparam int SHORT_FRAME_BYTES_DEF = 8;

    // Marker byte values
    localparam logic [7:0] START_MARK = 8'hFF;
    localparam logic [7:0] END_MARK   = 8'hFE;

    // Width of the frame length field and number of bytes a result reports
    localparam int LEN_W        = 5;
    localparam int REPORT_BYTES = 20;

    // One result item
    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic [63:0]      bytes_low;
        logic [63:0]      bytes_middle;
        logic [31:0]      bytes_high;
    } mfe_result_t;

endpackage

// File: sv/mfe_scan.sv
// Single-pass window update: append a byte, find the frame start and extract a frame.
module mfe_scan
    import mfe_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF,
    localparam int WinDepth = (LONG_FRAME_BYTES > SHORT_FRAME_BYTES) ?
                              LONG_FRAME_BYTES : SHORT_FRAME_BYTES,
    localparam int PosW     = $clog2(WinDepth + 1)
)
(
    input  logic                  frame_mode,
    input  logic [7:0]            data_byte,
    input  logic [WinDepth*8-1:0] win_bytes,
    input  logic [WinDepth-1:0]   win_valid,
    output logic [WinDepth*8-1:0] next_bytes,
    output logic [WinDepth-1:0]   next_valid,
    output logic                  emit,
    output mfe_result_t           result
);

    localparam logic [LEN_W-1:0] LongLen  = LEN_W'(LONG_FRAME_BYTES);
    localparam logic [LEN_W-1:0] ShortLen = LEN_W'(SHORT_FRAME_BYTES);

    logic                      win_full;
    logic [WinDepth-1:0]       first_free;
    logic [WinDepth*8-1:0]     app_bytes;
    logic [WinDepth-1:0]       app_valid;
    logic [WinDepth-1:0]       cand;
    logic [WinDepth-1:0]       full_long;
    logic [WinDepth-1:0]       full_short;
    logic [WinDepth-1:0]       mark_long;
    logic [WinDepth-1:0]       mark_short;
    logic [WinDepth-1:0]       full_sel;
    logic [WinDepth-1:0]       mark_sel;
    logic [WinDepth-1:0]       stop;
    logic                      found;
    logic                      start_emit;
    logic [PosW-1:0]           start_pos;
    logic [WinDepth*8-1:0]     sh_bytes;
    logic [WinDepth-1:0]       sh_valid;
    logic [REPORT_BYTES*8-1:0] frame_vec;

    assign win_full = win_valid[WinDepth-1];

    // Append the byte at the first free entry, or drop the oldest when full
    for (genvar i = 0; i < WinDepth; i++) begin : g_append
        if (i == 0) begin : g_first
            assign first_free[i] = !win_valid[i];
        end
        else begin : g_rest
            assign first_free[i] = win_valid[i-1] && !win_valid[i];
        end

        if (i == WinDepth - 1) begin : g_top
            assign app_bytes[i*8 +: 8] = (win_full || first_free[i]) ?
                                         data_byte : win_bytes[i*8 +: 8];
        end
        else begin : g_low
            assign app_bytes[i*8 +: 8] = win_full ? win_bytes[(i+1)*8 +: 8] :
                                         first_free[i] ? data_byte : win_bytes[i*8 +: 8];
        end

        assign app_valid[i] = win_full || win_valid[i] || first_free[i];
    end

    // Flag each start candidate and whether its frame is complete and well marked
    for (genvar i = 0; i < WinDepth; i++) begin : g_flags
        assign cand[i] = app_valid[i] && (app_bytes[i*8 +: 8] == START_MARK);

        if (i + LONG_FRAME_BYTES - 1 < WinDepth) begin : g_long_in
            assign full_long[i] = app_valid[i + LONG_FRAME_BYTES - 1];
            assign mark_long[i] =
                app_bytes[(i + LONG_FRAME_BYTES - 2)*8 +: 8] == END_MARK;
        end
        else begin : g_long_out
            assign full_long[i] = 1'b0;
            assign mark_long[i] = 1'b0;
        end

        if (i + SHORT_FRAME_BYTES - 1 < WinDepth) begin : g_short_in
            assign full_short[i] = app_valid[i + SHORT_FRAME_BYTES - 1];
            assign mark_short[i] =
                app_bytes[(i + SHORT_FRAME_BYTES - 1)*8 +: 8] == END_MARK;
        end
        else begin : g_short_out
            assign full_short[i] = 1'b0;
            assign mark_short[i] = 1'b0;
        end

        assign full_sel[i] = frame_mode ? full_long[i] : full_short[i];
        assign mark_sel[i] = frame_mode ? mark_long[i] : mark_short[i];

        // Search stops at an incomplete frame or at a matched one
        assign stop[i] = cand[i] && (!full_sel[i] || mark_sel[i]);
    end

    // Pick the oldest candidate where the search stops
    always_comb
    begin
        found      = 1'b0;
        start_emit = 1'b0;
        start_pos  = PosW'(WinDepth);
        for (int i = 0; i < WinDepth; i++)
        begin
            if (stop[i] && !found)
            begin
                found      = 1'b1;
                start_emit = full_sel[i] && mark_sel[i];
                start_pos  = PosW'(i);
            end
        end
    end

    assign emit = start_emit;

    // Drop everything ahead of the chosen start
    assign sh_bytes = app_bytes >> {start_pos, 3'b000};
    assign sh_valid = app_valid >> start_pos;

    // Consume the emitted frame
    always_comb
    begin
        next_bytes = sh_bytes;
        next_valid = sh_valid;
        if (start_emit)
        begin
            if (frame_mode)
            begin
                next_bytes = sh_bytes >> (LONG_FRAME_BYTES * 8);
                next_valid = sh_valid >> LONG_FRAME_BYTES;
            end
            else
            begin
                next_bytes = sh_bytes >> (SHORT_FRAME_BYTES * 8);
                next_valid = sh_valid >> SHORT_FRAME_BYTES;
            end
        end
    end

    // Pack the frame bytes, zero past the frame length
    for (genvar k = 0; k < REPORT_BYTES; k++) begin : g_pack
        if (k < WinDepth) begin : g_have
            assign frame_vec[k*8 +: 8] =
                ((frame_mode && (k < LONG_FRAME_BYTES)) ||
                 (!frame_mode && (k < SHORT_FRAME_BYTES))) ? sh_bytes[k*8 +: 8] : 8'h00;
        end
        else begin : g_none
            assign frame_vec[k*8 +: 8] = 8'h00;
        end
    end

    assign result.frame_length = frame_mode ? LongLen : ShortLen;
    assign result.bytes_low    = frame_vec[63:0];
    assign result.bytes_middle = frame_vec[127:64];
    assign result.bytes_high   = frame_vec[159:128];

endmodule

// File: sv/mfe_result_stage.sv
// Result register with valid/stall handshake toward the receiver.
module mfe_result_stage
    import mfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  mfe_result_t result_in,
    input  logic        out_stall,
    output logic        out_valid,
    output mfe_result_t result_out,
    output logic        slot_free
);

    logic        valid_reg;
    logic        valid_next;
    mfe_result_t result_reg;

    // Slot can take a new item when empty or being drained this cycle
    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// File: sv/marker_frame_extractor_core.sv
// Top level of the start/end marker frame extractor.
//
// Usage:
//   Bytes enter on data_byte with in_valid/in_stall; an item is taken at a
//   clock edge with in_valid high and in_stall low. Frames leave on
//   frame_length and bytes_low/middle/high with out_valid/out_stall.
//   A frame opens with 0xFF; frame_mode 0 selects short frames with 0xFE as
//   the last byte, frame_mode 1 selects long frames with 0xFE one byte before
//   the end. Write frame_mode through cfg_wr_en/cfg_wr_data while idle.
// Timing:
//   One byte per cycle while in_stall stays low. A byte is held in the input
//   register, then one combinational pass over the byte window updates the
//   window and loads the result register, which drives out_valid. Each byte
//   yields at most one frame.
// Reset:
//   Clears the window, the mode (short frames) and both valid flags.
// Back-pressure:
//   While out_stall holds a waiting frame, the input register still takes a
//   byte; in_stall rises only when that byte would produce a second frame.
module marker_frame_extractor_core
    import mfe_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LEN_W-1:0]  frame_length,
    output logic [63:0]       bytes_low,
    output logic [63:0]       bytes_middle,
    output logic [31:0]       bytes_high
);

    localparam int WinDepth = (LONG_FRAME_BYTES > SHORT_FRAME_BYTES) ?
                              LONG_FRAME_BYTES : SHORT_FRAME_BYTES;

    logic                  frame_mode_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic [WinDepth*8-1:0] win_bytes_reg;
    logic [WinDepth-1:0]   win_valid_reg;
    logic [WinDepth*8-1:0] win_bytes_next;
    logic [WinDepth-1:0]   win_valid_next;
    logic                  emit;
    logic                  slot_free;
    logic                  process;
    logic                  in_accept;
    mfe_result_t           scan_result;
    mfe_result_t           result_out;

    // Process the held item unless its frame has nowhere to go
    assign process   = in_valid_reg && (slot_free || !emit);
    assign in_stall  = in_valid_reg && !process;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Control state: mode, input valid, window occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            win_valid_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frame_mode_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            if (process)
            begin
                win_valid_reg <= win_valid_next;
            end
        end
    end

    // Payload: input byte and window contents
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
        end
        if (process)
        begin
            win_bytes_reg <= win_bytes_next;
        end
    end

    mfe_scan #(
        .LONG_FRAME_BYTES  (LONG_FRAME_BYTES),
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES)
    ) u_scan (
        .frame_mode (frame_mode_reg),
        .data_byte  (in_byte_reg),
        .win_bytes  (win_bytes_reg),
        .win_valid  (win_valid_reg),
        .next_bytes (win_bytes_next),
        .next_valid (win_valid_next),
        .emit       (emit),
        .result     (scan_result)
    );

    mfe_result_stage u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (process && emit),
        .result_in  (scan_result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (result_out),
        .slot_free  (slot_free)
    );

    assign frame_length = result_out.frame_length;
    assign bytes_low    = result_out.bytes_low;
    assign bytes_middle = result_out.bytes_middle;
    assign bytes_high   = result_out.bytes_high;

endmodule

// File: sv/mfe_checker.sv
// Port-level assertions for the marker frame extractor, bound to the top level.
module mfe_checker
    import mfe_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [LEN_W-1:0] frame_length,
    input logic [63:0]      bytes_low,
    input logic [63:0]      bytes_middle,
    input logic [31:0]      bytes_high
);

    localparam logic [LEN_W-1:0] LongLen  = LEN_W'(LONG_FRAME_BYTES);
    localparam logic [LEN_W-1:0] ShortLen = LEN_W'(SHORT_FRAME_BYTES);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_length) &&
        $stable(bytes_low) && $stable(bytes_middle) && $stable(bytes_high))
        else $error("result item changed while stalled");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the result side free");

    // Every frame opens with the start marker
    a_start_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bytes_low[7:0] == START_MARK)
        else $error("frame without start marker");

    // Frame length is one of the two configured sizes
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_length == LongLen) || (frame_length == ShortLen))
        else $error("illegal frame length");

    // No input stall and no valid result item right after reset releases
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_stall && !out_valid)
        else $error("activity right after reset");

endmodule

bind marker_frame_extractor_core mfe_checker #(
    .LONG_FRAME_BYTES  (LONG_FRAME_BYTES),
    .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES)
) u_mfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_length (frame_length),
    .bytes_low    (bytes_low),
    .bytes_middle (bytes_middle),
    .bytes_high   (bytes_high)
);
